// ----- hdl/assert_macros.svh -----
// Assertion macros for the drawing engine. Clock and reset are the house names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MFRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MFRF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MFRF_ASSERT(label, prop, msg)
`define MFRF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- hdl/mfrf_pkg.sv -----
`default_nettype none
package mfrf_pkg;

   localparam int PANEL_WIDTH  = 800;
   localparam int PANEL_HEIGHT = 480;
   localparam int STRIDE       = PANEL_WIDTH / 8;
   localparam int DRAW_COLS    = STRIDE * 8;
   localparam int STORE_BYTES  = STRIDE * PANEL_HEIGHT;

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int ROW_W  = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
   localparam int BC_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
   // Signed coordinate width: holds left + span_x and the panel limits.
   localparam int CRD_W  = 14;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0] FULL_BYTE = 8'hFF;
   localparam logic [7:0] LEAD_BIT  = 8'h80;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_FILL    = 2'd1,
      ACT_OUTLINE = 2'd2,
      ACT_READ    = 2'd3
   } mfrf_action_type;

   typedef enum logic [1:0] {
      JOB_CLEAR = 2'd0,
      JOB_BOX   = 2'd1,
      JOB_READ  = 2'd2,
      JOB_NOP   = 2'd3
   } mfrf_job_type;

   typedef enum logic {
      F_IDLE,
      F_EMIT
   } mfrf_fstate_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_CLR,
      B_RD,
      B_WR,
      B_READ,
      B_DONE
   } mfrf_bstate_type;

   // One unit of back-end work. A box is already clipped and non-empty.
   typedef struct packed {
      mfrf_job_type      job;
      logic              last;
      logic              black;
      logic              oob;
      logic [BC_W-1:0]   bc0;
      logic [BC_W-1:0]   bc_last;
      logic [2:0]        lo;
      logic [2:0]        hi;
      logic [ROW_W-1:0]  row0;
      logic [ROW_W-1:0]  row_last;
      logic [ADDR_W-1:0] base0;
      logic [ADDR_W-1:0] raddr;
   } mfrf_entry_type;

   typedef struct packed {
      logic           push;
      mfrf_entry_type entry;
   } mfrf_qctl_type;

   typedef struct packed {
      logic full;
      logic init_done;
   } mfrf_status_type;

   // Bits of one byte that cover columns lo..hi, MSB first.
   function automatic logic [7:0] byte_mask(input logic [2:0] lo, input logic [2:0] hi);
      logic [7:0] from_lo;
      logic [7:0] to_hi;
      from_lo = FULL_BYTE >> lo;
      to_hi   = ~((~LEAD_BIT) >> hi);
      return from_lo & to_hi;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/mfrf_req_if.sv -----
`default_nettype none
interface mfrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [11:0] left;
   logic [11:0] top;
   logic [10:0] span_x;
   logic [10:0] span_y;
   logic        ink_black;
   logic [15:0] byte_index;

   modport source (output valid, action, left, top, span_x, span_y, ink_black, byte_index,
                   input ready);
   modport sink (input valid, action, left, top, span_x, span_y, ink_black, byte_index,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/mfrf_rsp_if.sv -----
`default_nettype none
interface mfrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_valid;

   modport source (output valid, read_data, read_valid, input ready);
   modport sink (input valid, read_data, read_valid, output ready);
endinterface
`default_nettype wire

// ----- hdl/mfrf_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module mfrf_queue import mfrf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire mfrf_qctl_type  qctl,
   input  wire logic           pop,
   output mfrf_entry_type      head,
   output logic                empty,
   output logic                full
);

   mfrf_entry_type    entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = qctl.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (qctl.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !qctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qctl.push) begin
         entries_ff[wr_ptr_ff] <= qctl.entry;
      end
   end

   `MFRF_ASSERT(a_queue_no_overflow, qctl.push |-> !full, "push into a full queue")
   `MFRF_ASSERT(a_queue_no_underflow, pop |-> !empty, "pop from an empty queue")

endmodule
`default_nettype wire

// ----- hdl/mfrf_front.sv -----
`default_nettype none
`include "assert_macros.svh"
module mfrf_front import mfrf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   mfrf_req_if.sink             req_port,
   input  wire mfrf_status_type status,
   output mfrf_qctl_type        qctl
);

   localparam logic signed [CRD_W-1:0] ZERO  = '0;
   localparam logic signed [CRD_W-1:0] ONE   = CRD_W'(1);
   localparam logic signed [CRD_W-1:0] DCOLS = CRD_W'(DRAW_COLS);
   localparam logic signed [CRD_W-1:0] DROWS = CRD_W'(PANEL_HEIGHT);

   mfrf_fstate_type state_ff, state_in;
   logic [1:0]      sub_ff, sub_in;

   mfrf_action_type cmd_action_ff;
   logic [11:0]     cmd_left_ff;
   logic [11:0]     cmd_top_ff;
   logic [10:0]     cmd_span_x_ff;
   logic [10:0]     cmd_span_y_ff;
   logic            cmd_black_ff;
   logic [15:0]     cmd_index_ff;

   logic accept;
   logic span_zero;
   logic last;
   logic box_empty;
   logic signed [CRD_W-1:0] xs, ys, ws, hs;
   logic signed [CRD_W-1:0] bx0, bx1, by0, by1;
   logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1, xl, yl;
   mfrf_entry_type entry;

   assign accept = req_port.valid && req_port.ready;

   // Box for the current entry: the whole rectangle, or one outline edge.
   always_comb begin
      xs = {{(CRD_W - 12){cmd_left_ff[11]}}, cmd_left_ff};
      ys = {{(CRD_W - 12){cmd_top_ff[11]}}, cmd_top_ff};
      ws = {{(CRD_W - 11){1'b0}}, cmd_span_x_ff};
      hs = {{(CRD_W - 11){1'b0}}, cmd_span_y_ff};
      bx0 = xs;
      bx1 = xs + ws;
      by0 = ys;
      by1 = ys + hs;
      if (cmd_action_ff == ACT_OUTLINE) begin
         case (sub_ff)
            2'd0: by1 = ys + ONE;
            2'd1: by0 = ys + hs - ONE;
            2'd2: bx1 = xs + ONE;
            default: bx0 = xs + ws - ONE;
         endcase
      end
      cx0 = (bx0 < ZERO) ? ZERO : bx0;
      cy0 = (by0 < ZERO) ? ZERO : by0;
      cx1 = (bx1 > DCOLS) ? DCOLS : bx1;
      cy1 = (by1 > DROWS) ? DROWS : by1;
      xl  = cx1 - ONE;
      yl  = cy1 - ONE;
      box_empty = (cx0 >= cx1) || (cy0 >= cy1);
   end

   always_comb begin
      span_zero = (cmd_span_x_ff == '0) || (cmd_span_y_ff == '0);
      last = (cmd_action_ff != ACT_OUTLINE) || span_zero || (sub_ff == 2'd3);

      entry.last     = last;
      entry.black    = cmd_black_ff;
      entry.oob      = !(32'(cmd_index_ff) < 32'(STORE_BYTES));
      entry.raddr    = ADDR_W'(cmd_index_ff);
      entry.bc0      = cx0[BC_W+2:3];
      entry.bc_last  = xl[BC_W+2:3];
      entry.lo       = cx0[2:0];
      entry.hi       = xl[2:0];
      entry.row0     = cy0[ROW_W-1:0];
      entry.row_last = yl[ROW_W-1:0];
      entry.base0    = ADDR_W'(cy0[ROW_W-1:0] * STRIDE);
      unique case (cmd_action_ff) inside
         ACT_CLEAR: entry.job = JOB_CLEAR;
         ACT_READ:  entry.job = JOB_READ;
         ACT_FILL, ACT_OUTLINE: entry.job = (span_zero || box_empty) ? JOB_NOP : JOB_BOX;
         default:   entry.job = JOB_NOP;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = F_EMIT;
         F_EMIT: if (!status.full && last) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_port.ready = (state_ff == F_IDLE) && status.init_done;
      qctl.push      = (state_ff == F_EMIT) && !status.full;
      qctl.entry     = entry;
      sub_in         = sub_ff;
      if (accept) begin
         sub_in = '0;
      end else if (qctl.push) begin
         sub_in = sub_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_action_ff <= mfrf_action_type'(req_port.action);
         cmd_left_ff   <= req_port.left;
         cmd_top_ff    <= req_port.top;
         cmd_span_x_ff <= req_port.span_x;
         cmd_span_y_ff <= req_port.span_y;
         cmd_black_ff  <= req_port.ink_black;
         cmd_index_ff  <= req_port.byte_index;
      end
   end

   `MFRF_ASSERT(a_front_accept_emits, accept |=> state_ff == F_EMIT, "accept did not start emit")

endmodule
`default_nettype wire

// ----- hdl/mfrf_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module mfrf_back import mfrf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire mfrf_entry_type head,
   input  wire logic           empty,
   output logic                pop,
   output logic                init_done,
   mfrf_rsp_if.source          rsp_port
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   mfrf_bstate_type   state_ff, state_in;
   mfrf_entry_type    ent_ff, ent_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BC_W-1:0]   bc_ff, bc_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic [7:0]        frame_store_ff [STORE_BYTES];
   logic [7:0]        rd_data_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_rvalid_ff;

   logic              slot_free;
   logic              rsp_load;
   logic              rd_en;
   logic              wr_en;
   logic [ADDR_W-1:0] box_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        mask;
   logic              row_end;
   logic              box_end;

   assign slot_free = !rsp_valid_ff || rsp_port.ready;
   assign box_addr  = base_ff + ADDR_W'(bc_ff);
   assign row_end   = (bc_ff == ent_ff.bc_last);
   assign box_end   = row_end && (row_ff == ent_ff.row_last);
   assign mask      = byte_mask((bc_ff == ent_ff.bc0) ? ent_ff.lo : 3'd0,
                                row_end ? ent_ff.hi : 3'd7);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_INIT: if (clr_ff == LAST_ADDR) state_in = B_IDLE;
         B_IDLE: begin
            if (!empty) begin
               unique case (head.job)
                  JOB_CLEAR: state_in = B_CLR;
                  JOB_BOX:   state_in = B_RD;
                  JOB_READ:  state_in = B_READ;
                  default:   state_in = B_DONE;
               endcase
            end
         end
         B_CLR:  if (clr_ff == LAST_ADDR) state_in = B_DONE;
         B_RD:   state_in = B_WR;
         B_WR:   state_in = box_end ? B_DONE : B_RD;
         B_READ: state_in = B_DONE;
         B_DONE: if (!ent_ff.last || slot_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      init_done = (state_ff != B_INIT);
      pop       = (state_ff == B_IDLE) && !empty;
      rd_en     = (state_ff == B_RD) || (state_ff == B_READ);
      rd_addr   = (state_ff == B_READ) ? ent_ff.raddr : box_addr;
      wr_en     = (state_ff == B_INIT) || (state_ff == B_CLR) || (state_ff == B_WR);
      wr_addr   = (state_ff == B_WR) ? box_addr : clr_ff;
      wr_data   = FULL_BYTE;
      if (state_ff == B_WR) begin
         wr_data = ent_ff.black ? (rd_data_ff & ~mask) : (rd_data_ff | mask);
      end
      rsp_load  = (state_ff == B_DONE) && ent_ff.last && slot_free;
   end

   always_comb begin
      ent_in  = pop ? head : ent_ff;
      clr_in  = clr_ff;
      row_in  = row_ff;
      bc_in   = bc_ff;
      base_in = base_ff;
      case (state_ff) inside
         B_INIT, B_CLR: clr_in = clr_ff + 1'b1;
         B_IDLE: begin
            clr_in  = '0;
            row_in  = head.row0;
            bc_in   = head.bc0;
            base_in = head.base0;
         end
         B_WR: begin
            if (row_end) begin
               bc_in   = ent_ff.bc0;
               row_in  = row_ff + 1'b1;
               base_in = base_ff + ADDR_W'(STRIDE);
            end else begin
               bc_in = bc_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      row_ff  <= row_in;
      bc_ff   <= bc_in;
      base_ff <= base_in;
      if (rsp_load) begin
         rsp_rvalid_ff <= (ent_ff.job == JOB_READ);
         rsp_data_ff   <= ((ent_ff.job == JOB_READ) && !ent_ff.oob) ? rd_data_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.read_data  = rsp_data_ff;
   assign rsp_port.read_valid = rsp_rvalid_ff;

   `MFRF_ASSERT(a_back_wr_after_rd, state_ff == B_WR |-> $past(state_ff) == B_RD, "lone write")
   `MFRF_ASSERT(a_back_slot_free, rsp_load |-> slot_free, "result overwrote a waiting item")

endmodule
`default_nettype wire

// ----- hdl/mono_framebuffer_rect_fill.sv -----
// A read item goes through the queue to the back end, which reads the store byte and then
// loads the result register; a fill or outline item reads, then writes, each touched store
// byte of each entry. A clear item sweeps all 48000 store bytes, one byte per cycle.
// The back end runs one queue entry at a time through the single-port store;
// the front end queues all entries of an item, stalling on a full queue, before taking more.
// Reset: synchronous, active high; the store is then swept to white.
`default_nettype none
module mono_framebuffer_rect_fill import mfrf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   mfrf_req_if.sink     req_port,
   mfrf_rsp_if.source   rsp_port
);

   // The front end latches an item, clips it, and splits an outline into top, bottom, left and
   // right edges. Each edge or rectangle becomes one queue entry holding the clipped byte range.
   mfrf_qctl_type   qctl;
   mfrf_status_type status;
   mfrf_entry_type  head;
   logic            q_empty;
   logic            q_full;
   logic            q_pop;
   logic            init_done;

   // A full queue holds back the front end's pushes, and the power-on clearing sweep its intake.
   // req_port.ready stays low for the whole sweep.
   assign status.full      = q_full;
   assign status.init_done = init_done;

   mfrf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .status   (status),
      .qctl     (qctl)
   );

   // The queue lets the front end prepare the next edges while the back end is busy.
   mfrf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qctl  (qctl),
      .pop   (q_pop),
      .head  (head),
      .empty (q_empty),
      .full  (q_full)
   );

   // The back end owns the frame store. It walks each entry row by row and byte by byte,
   // and loads the result register when the last entry of an item is done, so results
   // leave in item order.
   mfrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .init_done (init_done),
      .rsp_port  (rsp_port)
   );

endmodule
`default_nettype wire
